@@ hdl/lrx_pkg.sv @@
// package for the lr35902 subset execute block
// phase codes, opcodes, flag bits and reset values; no dependencies
`default_nettype none
package lrx_pkg;

  localparam logic [15:0] START_PC_RESET = 16'h0200;
  localparam logic [15:0] START_SP_RESET = 16'hCFF5;
  localparam logic [15:0] DE_RESET       = 16'h00D8;
  localparam logic [15:0] HL_RESET       = 16'hFFE2;
  localparam logic [15:0] HIGH_PAGE      = 16'hFF00;

  localparam logic [3:0] FZ = 4'h8;
  localparam logic [3:0] FH = 4'h2;
  localparam logic [3:0] FC = 4'h1;

  typedef enum logic [3:0] {
    PH_START, PH_FETCH, PH_OPC, PH_IMM8, PH_IMM_LO, PH_IMM_HI,
    PH_PUSH_LO, PH_POP_LO, PH_POP_HI, PH_DATA, PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0, ST_HALT = 2'd1, ST_ILLEGAL = 2'd2
  } status_t;

  localparam logic [7:0] OP_NOP_HALT = 8'h00;
  localparam logic [7:0] OP_LD_C_N   = 8'h0E;
  localparam logic [7:0] OP_LD_DE_NN = 8'h11;
  localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
  localparam logic [7:0] OP_JR_NZ    = 8'h20;
  localparam logic [7:0] OP_LD_HL_NN = 8'h21;
  localparam logic [7:0] OP_LD_SP_NN = 8'h31;
  localparam logic [7:0] OP_LDD_HL_A = 8'h32;
  localparam logic [7:0] OP_INC_A    = 8'h3C;
  localparam logic [7:0] OP_LD_A_N   = 8'h3E;
  localparam logic [7:0] OP_LD_HL_A  = 8'h77;
  localparam logic [7:0] OP_AND_C    = 8'hA1;
  localparam logic [7:0] OP_XOR_A    = 8'hAF;
  localparam logic [7:0] OP_POP_BC   = 8'hC1;
  localparam logic [7:0] OP_JP       = 8'hC3;
  localparam logic [7:0] OP_PREFIX   = 8'hCB;
  localparam logic [7:0] OP_CALL     = 8'hCD;
  localparam logic [7:0] OP_POP_DE   = 8'hD1;
  localparam logic [7:0] OP_RETI     = 8'hD9;
  localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
  localparam logic [7:0] OP_POP_HL   = 8'hE1;
  localparam logic [7:0] OP_LD_IC_A  = 8'hE2;
  localparam logic [7:0] OP_POP_AF   = 8'hF1;
  localparam logic [7:0] CB_BIT7_H   = 8'h7C;

  localparam int unsigned CFG_START_PC = 0;
  localparam int unsigned CFG_START_SP = 1;

  typedef struct packed {
    logic [15:0] bus_address;
    logic        is_write;
    logic [7:0]  write_data;
    logic        opcode_fetch;
    logic [1:0]  run_status;
    logic [7:0]  accumulator;
    logic [3:0]  flags;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/lrx_if.sv @@
// valid/ready channel interfaces for the lr35902 subset block
// depends on lrx_pkg for the result struct
`default_nettype none
interface lrx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

interface lrx_out_if import lrx_pkg::*; ;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lrx_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

@@ hdl/lr35902_subset_execute.sv @@
//  channel | dir | payload                          | beat when
//  in_ch   | in  | read_data                        | valid && ready
//  out_ch  | out | bus access, status, a, flags     | valid && ready
//  cfg     | in  | index (0 start_pc, 1 start_sp)   | valid && ready
// one beat per clock while the output is not stalled: an input beat is decoded in the cycle it is accepted
// and its access lands in the output register at that edge.
// a new input is taken whenever the output register is empty or being drained.
// rst (synchronous) returns to the start phase; pc and sp load from the start registers at first beat.
// depends on lrx_pkg, lrx_if and lrx_core
`default_nettype none
module lr35902_subset_execute import lrx_pkg::*; #(
  parameter logic [15:0] StartPcReset = START_PC_RESET,
  parameter logic [15:0] StartSpReset = START_SP_RESET
) (
  input wire logic   clk,
  input wire logic   rst,
  lrx_in_if.sink     in_ch,
  lrx_out_if.source  out_ch,
  lrx_cfg_if.sink    cfg
);

  logic [15:0] start_pc, start_sp;
  phase_t      phase, phase_next;
  logic [7:0]  a, a_next, opl, opl_next;
  logic [3:0]  f, f_next;
  logic [15:0] bc, bc_next, de, de_next, hl, hl_next;
  logic [15:0] sp, sp_next, pc, pc_next, operand, operand_next;
  status_t     status, status_next;
  result_t     res;
  logic        take;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;
  assign cfg.ready = 1'b1;

  lrx_core u_core (
    .d(in_ch.read_data), .start_pc(start_pc), .start_sp(start_sp),
    .phase(phase), .a(a), .f(f), .bc(bc), .de(de), .hl(hl), .sp(sp), .pc(pc),
    .opl(opl), .operand(operand), .status(status),
    .phase_next(phase_next), .a_next(a_next), .f_next(f_next),
    .bc_next(bc_next), .de_next(de_next), .hl_next(hl_next),
    .sp_next(sp_next), .pc_next(pc_next), .opl_next(opl_next),
    .operand_next(operand_next), .status_next(status_next), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= StartPcReset;
      start_sp <= StartSpReset;
    end else if (cfg.valid) begin
      if (cfg.index == 1'(CFG_START_PC)) start_pc <= cfg.wdata;
      else start_sp <= cfg.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      a <= 8'h00;
      f <= FZ;
      bc <= 16'h0000;
      de <= DE_RESET;
      hl <= HL_RESET;
      sp <= 16'h0000;
      pc <= 16'h0000;
      opl <= 8'h00;
      operand <= 16'h0000;
      status <= ST_RUN;
      out_ch.valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        a <= a_next;
        f <= f_next;
        bc <= bc_next;
        de <= de_next;
        hl <= hl_next;
        sp <= sp_next;
        pc <= pc_next;
        opl <= opl_next;
        operand <= operand_next;
        status <= status_next;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_ch.data <= res;
  end

endmodule
`default_nettype wire

@@ hdl/lrx_core.sv @@
// combinational next-state and next-access logic for one bus beat
// depends on lrx_pkg
`default_nettype none
module lrx_core import lrx_pkg::*; (
  input  wire logic [7:0]  d,
  input  wire logic [15:0] start_pc,
  input  wire logic [15:0] start_sp,
  input  wire phase_t      phase,
  input  wire logic [7:0]  a,
  input  wire logic [3:0]  f,
  input  wire logic [15:0] bc,
  input  wire logic [15:0] de,
  input  wire logic [15:0] hl,
  input  wire logic [15:0] sp,
  input  wire logic [15:0] pc,
  input  wire logic [7:0]  opl,
  input  wire logic [15:0] operand,
  input  wire status_t     status,
  output phase_t           phase_next,
  output logic [7:0]       a_next,
  output logic [3:0]       f_next,
  output logic [15:0]      bc_next,
  output logic [15:0]      de_next,
  output logic [15:0]      hl_next,
  output logic [15:0]      sp_next,
  output logic [15:0]      pc_next,
  output logic [7:0]       opl_next,
  output logic [15:0]      operand_next,
  output status_t          status_next,
  output result_t          res
);

  logic [15:0] w;
  logic [7:0]  a_inc;
  logic [7:0]  a_and;
  logic [15:0] pc1;

  assign w     = {d, operand[7:0]};
  assign a_inc = a + 8'd1;
  assign a_and = a & bc[7:0];
  assign pc1   = pc + 16'd1;

  always_comb begin
    phase_next   = phase;
    a_next       = a;
    f_next       = f;
    bc_next      = bc;
    de_next      = de;
    hl_next      = hl;
    sp_next      = sp;
    pc_next      = pc;
    opl_next     = opl;
    operand_next = operand;
    status_next  = status;
    res.bus_address  = pc;
    res.is_write     = 1'b0;
    res.write_data   = 8'h00;
    res.opcode_fetch = 1'b0;
    case (phase)
      PH_START: begin
        pc_next = start_pc;
        sp_next = start_sp;
        res.bus_address = start_pc;
        res.opcode_fetch = 1'b1;
        phase_next = PH_OPC;
      end
      PH_FETCH: begin
        res.opcode_fetch = 1'b1;
        phase_next = PH_OPC;
      end
      PH_OPC: begin
        opl_next = d;
        pc_next = pc1;
        // defaults before the opcode decode: next fetch at pc+1
        res.bus_address = pc1;
        res.opcode_fetch = 1'b1;
        phase_next = PH_OPC;
        case (d)
          OP_NOP_HALT: begin
            status_next = ST_HALT;
            phase_next = PH_HALT;
            res.opcode_fetch = 1'b0;
          end
          OP_INC_A: begin
            a_next = a_inc;
            f_next = (f & FC) | ((a_inc == 8'h00) ? FZ : 4'h0)
                   | ((a_inc[3:0] == 4'h0) ? FH : 4'h0);
          end
          OP_AND_C: begin
            a_next = a_and;
            f_next = FH | ((a_and == 8'h00) ? FZ : 4'h0);
          end
          OP_XOR_A: begin
            a_next = 8'h00;
            f_next = FZ;
          end
          OP_LD_C_N, OP_LD_A_N, OP_JR_NZ, OP_LDH_N_A, OP_PREFIX: begin
            pc_next = pc + 16'd2;
            res.opcode_fetch = 1'b0;
            phase_next = PH_IMM8;
          end
          OP_LD_DE_NN, OP_LD_HL_NN, OP_LD_SP_NN, OP_JP, OP_CALL: begin
            pc_next = pc + 16'd2;
            res.opcode_fetch = 1'b0;
            phase_next = PH_IMM_LO;
          end
          OP_LD_A_DE: begin
            res.bus_address = de;
            res.opcode_fetch = 1'b0;
            phase_next = PH_DATA;
          end
          OP_LDD_HL_A, OP_LD_HL_A, OP_LD_IC_A: begin
            res.bus_address = (d == OP_LD_IC_A) ? (HIGH_PAGE | {8'h00, bc[7:0]}) : hl;
            if (d == OP_LDD_HL_A) hl_next = hl - 16'd1;
            res.is_write = 1'b1;
            res.write_data = a;
            res.opcode_fetch = 1'b0;
            phase_next = PH_FETCH;
          end
          OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF, OP_RETI: begin
            res.bus_address = sp;
            sp_next = sp + 16'd1;
            res.opcode_fetch = 1'b0;
            phase_next = PH_POP_LO;
          end
          default: begin
            status_next = ST_ILLEGAL;
            phase_next = PH_HALT;
            res.opcode_fetch = 1'b0;
          end
        endcase
      end
      PH_IMM8: begin
        res.opcode_fetch = 1'b1;
        phase_next = PH_OPC;
        case (opl)
          OP_LD_C_N: bc_next = {bc[15:8], d};
          OP_LD_A_N: a_next = d;
          OP_JR_NZ: begin
            if ((f & FZ) == 4'h0) begin
              pc_next = pc + {{8{d[7]}}, d};
              res.bus_address = pc + {{8{d[7]}}, d};
            end
          end
          OP_LDH_N_A: begin
            res.bus_address = HIGH_PAGE | {8'h00, d};
            res.is_write = 1'b1;
            res.write_data = a;
            res.opcode_fetch = 1'b0;
            phase_next = PH_FETCH;
          end
          default: begin
            if (d != CB_BIT7_H) begin
              status_next = ST_ILLEGAL;
              phase_next = PH_HALT;
              res.opcode_fetch = 1'b0;
            end else begin
              f_next = (f & FC) | FH | (hl[15] ? 4'h0 : FZ);
            end
          end
        endcase
      end
      PH_IMM_LO: begin
        operand_next = {8'h00, d};
        pc_next = pc1;
        phase_next = PH_IMM_HI;
      end
      PH_IMM_HI: begin
        res.opcode_fetch = 1'b1;
        phase_next = PH_OPC;
        case (opl)
          OP_LD_DE_NN: de_next = w;
          OP_LD_HL_NN: hl_next = w;
          OP_LD_SP_NN: sp_next = w;
          OP_JP: begin
            pc_next = w;
            res.bus_address = w;
          end
          default: begin
            operand_next = w;
            sp_next = sp - 16'd1;
            res.bus_address = sp - 16'd1;
            res.is_write = 1'b1;
            res.write_data = pc[15:8];
            res.opcode_fetch = 1'b0;
            phase_next = PH_PUSH_LO;
          end
        endcase
      end
      PH_PUSH_LO: begin
        sp_next = sp - 16'd1;
        pc_next = operand;
        res.bus_address = sp - 16'd1;
        res.is_write = 1'b1;
        res.write_data = pc[7:0];
        phase_next = PH_FETCH;
      end
      PH_POP_LO: begin
        operand_next = {8'h00, d};
        res.bus_address = sp;
        sp_next = sp + 16'd1;
        phase_next = PH_POP_HI;
      end
      PH_POP_HI: begin
        res.opcode_fetch = 1'b1;
        phase_next = PH_OPC;
        case (opl)
          OP_POP_BC: bc_next = w;
          OP_POP_DE: de_next = w;
          OP_POP_HL: hl_next = w;
          OP_POP_AF: begin
            a_next = w[15:8];
            f_next = w[7:4];
          end
          default: begin
            pc_next = w;
            res.bus_address = w;
          end
        endcase
      end
      PH_DATA: begin
        a_next = d;
        res.opcode_fetch = 1'b1;
        phase_next = PH_OPC;
      end
      default: ;
    endcase
    res.run_status  = status_next;
    res.accumulator = a_next;
    res.flags       = f_next;
  end

endmodule
`default_nettype wire
